// File: rtl/hpa_pkg.sv
// Shared types and constants for the handle pool allocator.
// No dependencies; every other file but hpa_ram imports this package.
package hpa_pkg;

  localparam int unsigned PoolSize = 256;
  localparam int unsigned HandleW  = $clog2(PoolSize);
  localparam int unsigned CountW   = $clog2(PoolSize + 1);

  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_TRY     = 2'd1,
    CMD_RELEASE = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK          = 2'd0,
    STAT_NONE_FREE   = 2'd1,
    STAT_BAD_RELEASE = 2'd2,
    STAT_EXHAUSTED   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    FSM_CLEAR = 3'b001,
    FSM_IDLE  = 3'b010,
    FSM_EXEC  = 3'b100
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic clear;
    logic accept;
    logic commit;
  } hpa_ctrl_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
    logic clear_last;
  } hpa_stat_t;

  // Advance a queue position, wrapping at the pool size
  function automatic logic [HandleW-1:0] next_pos(logic [HandleW-1:0] pos);
    logic [CountW-1:0] inc;
    inc = CountW'(pos) + CountW'(1);
    if (inc >= CountW'(PoolSize)) begin
      return '0;
    end
    return inc[HandleW-1:0];
  endfunction

endpackage

// File: rtl/handle_pool_allocator.sv
// Handle pool allocator with a FIFO free list: top level.
// Depends on hpa_pkg, hpa_ctrl, hpa_dp (and hpa_ram below it).
//
// Hands out handles 0..255. Allocate (cmd 0) reuses the oldest released
// handle, else issues a fresh one, else reports the pool exhausted; try
// allocate (cmd 1) gives a released handle only; release (cmd 2) returns a
// handle that is in use and flags any other. Each item yields one result.
// After reset the in-use bitmap RAM is cleared one entry per cycle, and the
// input stalls until every entry is cleared. An item is first accepted, which
// starts the free-queue and bitmap RAM reads; then, once the output register
// is free, the bitmap and pointers are updated and the output register loaded;
// the next item is taken in the cycle after that, never before. While a
// result waits in the output register the block still accepts one further
// item, whose result then waits until the output register is taken.
module handle_pool_allocator import hpa_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  logic [1:0]   cmd_i,
  input  logic [7:0]   release_handle_i,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output logic [7:0]   granted_handle_o,
  output logic [1:0]   status_o
);

  hpa_ctrl_t ctrl;
  hpa_stat_t stat;

  hpa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  hpa_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctrl_i           (ctrl),
    .stat_o           (stat),
    .cmd_i            (cmd_i),
    .release_handle_i (release_handle_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .granted_handle_o (granted_handle_o),
    .status_o         (status_o)
  );

endmodule

// File: rtl/hpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hpa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/hpa_ctrl.sv
// Controller state machine for the handle pool allocator.
// Depends on hpa_pkg; drives clear/accept/commit commands into hpa_dp.
module hpa_ctrl import hpa_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  hpa_stat_t stat_i,
  output hpa_ctrl_t ctrl_o
);

  state_e state_q, state_d;

  always_comb begin
    state_d       = state_q;
    ctrl_o.clear  = 1'b0;
    ctrl_o.accept = 1'b0;
    ctrl_o.commit = 1'b0;
    unique case (state_q)
      FSM_CLEAR: begin
        // zero one bitmap entry per cycle
        ctrl_o.clear = 1'b1;
        if (stat_i.clear_last) begin
          state_d = FSM_IDLE;
        end
      end
      FSM_IDLE: begin
        if (in_valid_i) begin
          ctrl_o.accept = 1'b1;
          state_d       = FSM_EXEC;
        end
      end
      FSM_EXEC: begin
        // hold the item until the output register can take its result
        if (stat_i.out_free) begin
          ctrl_o.commit = 1'b1;
          state_d       = FSM_IDLE;
        end
      end
      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != FSM_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: rtl/hpa_dp.sv
// Datapath: free queue pointers, in-use bitmap, fresh counter, output register.
// Depends on hpa_pkg and hpa_ram; commanded by hpa_ctrl.
module hpa_dp import hpa_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  hpa_ctrl_t          ctrl_i,
  output hpa_stat_t          stat_o,
  input  logic [1:0]         cmd_i,
  input  logic [HandleW-1:0] release_handle_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [HandleW-1:0] granted_handle_o,
  output logic [1:0]         status_o
);

  logic [HandleW-1:0]  head_q, head_d, tail_q, tail_d, clr_q, clr_d;
  logic [CountW-1:0]   count_q, count_d, fresh_q, fresh_d;
  logic                out_valid_q, out_valid_d;

  logic [1:0]          cmd_q, cmd_d;
  logic [HandleW-1:0]  rel_q, rel_d;
  logic                pop_q, pop_d;
  logic [HandleW-1:0]  granted_q, granted_d;
  logic [1:0]          status_q, status_d;

  logic                ram_we, ram_re;
  logic [HandleW-1:0]  ram_rdata;
  logic                map_we, map_re, map_wdata, map_rdata;
  logic [HandleW-1:0]  map_waddr;
  logic                rel_ok;

  hpa_ram #(
    .Width (HandleW),
    .Depth (PoolSize)
  ) u_free_queue (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tail_q),
    .wdata_i (rel_q),
    .re_i    (ram_re),
    .raddr_i (head_q),
    .rdata_o (ram_rdata)
  );

  hpa_ram #(
    .Width (1),
    .Depth (PoolSize)
  ) u_in_use (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .re_i    (map_re),
    .raddr_i (release_handle_i),
    .rdata_o (map_rdata)
  );

  assign stat_o.out_free   = !out_valid_q || !out_stall_i;
  assign stat_o.clear_last = (clr_q == HandleW'(PoolSize - 1));

  assign rel_ok = (CountW'(rel_q) < CountW'(PoolSize)) && map_rdata
                  && (count_q < CountW'(PoolSize));

  always_comb begin
    head_d    = head_q;
    tail_d    = tail_q;
    count_d   = count_q;
    fresh_d   = fresh_q;
    clr_d     = clr_q;
    cmd_d     = cmd_q;
    rel_d     = rel_q;
    pop_d     = pop_q;
    granted_d = granted_q;
    status_d  = status_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    map_we    = 1'b0;
    map_re    = 1'b0;
    map_waddr = clr_q;
    map_wdata = 1'b0;

    // clear the bitmap one entry at a time after reset
    if (ctrl_i.clear) begin
      map_we = 1'b1;
      clr_d  = next_pos(clr_q);
    end

    // latch the item and start the queue and bitmap reads
    if (ctrl_i.accept) begin
      cmd_d  = cmd_i;
      rel_d  = release_handle_i;
      pop_d  = ((cmd_i == CMD_ALLOC) || (cmd_i == CMD_TRY)) && (count_q != '0);
      ram_re = pop_d;
      map_re = (cmd_i == CMD_RELEASE);
    end

    if (ctrl_i.commit) begin
      granted_d = '0;
      status_d  = STAT_NONE_FREE;
      unique case (cmd_q)
        CMD_ALLOC, CMD_TRY: begin
          if (pop_q) begin
            granted_d = ram_rdata;
            map_we    = 1'b1;
            map_waddr = ram_rdata;
            map_wdata = 1'b1;
            head_d    = next_pos(head_q);
            count_d   = count_q - CountW'(1);
            status_d  = STAT_OK;
          end else if (cmd_q == CMD_TRY) begin
            status_d = STAT_NONE_FREE;
          end else if (fresh_q < CountW'(PoolSize)) begin
            granted_d = fresh_q[HandleW-1:0];
            map_we    = 1'b1;
            map_waddr = fresh_q[HandleW-1:0];
            map_wdata = 1'b1;
            fresh_d   = fresh_q + CountW'(1);
            status_d  = STAT_OK;
          end else begin
            status_d = STAT_EXHAUSTED;
          end
        end
        CMD_RELEASE: begin
          if (rel_ok) begin
            map_we    = 1'b1;
            map_waddr = rel_q;
            map_wdata = 1'b0;
            ram_we    = 1'b1;
            tail_d    = next_pos(tail_q);
            count_d   = count_q + CountW'(1);
            status_d  = STAT_OK;
          end else begin
            status_d = STAT_BAD_RELEASE;
          end
        end
        default: begin
          status_d = STAT_NONE_FREE;
        end
      endcase
    end

    out_valid_d = ctrl_i.commit || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      fresh_q     <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      fresh_q     <= fresh_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    rel_q     <= rel_d;
    pop_q     <= pop_d;
    granted_q <= granted_d;
    status_q  <= status_d;
  end

  assign out_valid_o      = out_valid_q;
  assign granted_handle_o = granted_q;
  assign status_o         = status_q;

endmodule

// File: rtl/hpa_checker.sv
// Port-level checks for the handle pool allocator, bound to the top level.
// Depends on hpa_pkg and handle_pool_allocator.
module hpa_checker import hpa_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] granted_handle_o,
  input logic [1:0] status_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(granted_handle_o)
      && $stable(status_o))
    else $error("stalled result changed");

  // a failed command hands out no handle
  a_grant_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != STAT_OK) |-> granted_handle_o == '0)
    else $error("handle given with failing status");

  // an accepted item keeps the input side busy for its execute cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while an item executes");

  // a new result only comes out of the execute cycle
  a_result_from_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without an executing item");

endmodule

bind handle_pool_allocator hpa_checker u_hpa_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .granted_handle_o (granted_handle_o),
  .status_o         (status_o)
);

// File: sim/handle_pool_allocator_test.sv
// Self-checking testbench for handle_pool_allocator: a directed table, then random
// allocate/try/release/unknown traffic, checked against table rows or a pool predictor.
// Depends on hpa_pkg and the handle_pool_allocator RTL.
module handle_pool_allocator_test;
  import hpa_pkg::*;

  localparam logic [1:0] CmdUnknown = 2'd3;
  localparam int unsigned ExhaustTarget = 6;
  localparam int unsigned MixItems = 95;

  typedef struct packed {
    logic [HandleW-1:0] handle;
    status_e            status;
  } grant_t;

  typedef struct {
    logic [1:0]         cmd;
    logic [HandleW-1:0] rel;
    bit                 known;
    logic [HandleW-1:0] handle;
    status_e            status;
  } pool_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [1:0]         cmd_i;
  logic [7:0]         release_handle_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [7:0]         granted_handle_o;
  logic [1:0]         status_o;

  handle_pool_allocator dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .cmd_i            (cmd_i),
    .release_handle_i (release_handle_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .granted_handle_o (granted_handle_o),
    .status_o         (status_o)
  );

  // Predicted pool state
  logic [HandleW-1:0] recycled_q[$];
  bit                 held[PoolSize];
  int unsigned        next_fresh;

  grant_t      grant_q[$];
  int unsigned fail_count;
  int unsigned exhaust_hits;
  int unsigned burst_left;

  // Directed rows, starting from reset
  pool_row_t pool_rows[22] = '{
    '{CMD_TRY,     8'd0,   1'b1, 8'd0, STAT_NONE_FREE},
    '{CMD_RELEASE, 8'd0,   1'b1, 8'd0, STAT_BAD_RELEASE},
    '{CMD_RELEASE, 8'd255, 1'b1, 8'd0, STAT_BAD_RELEASE},
    '{CmdUnknown,  8'd255, 1'b1, 8'd0, STAT_NONE_FREE},
    '{CMD_ALLOC,   8'd255, 1'b1, 8'd0, STAT_OK},
    '{CMD_ALLOC,   8'd0,   1'b1, 8'd1, STAT_OK},
    '{CMD_ALLOC,   8'd0,   1'b1, 8'd2, STAT_OK},
    '{CMD_RELEASE, 8'd1,   1'b1, 8'd0, STAT_OK},
    '{CMD_RELEASE, 8'd1,   1'b1, 8'd0, STAT_BAD_RELEASE},
    '{CMD_RELEASE, 8'd0,   1'b1, 8'd0, STAT_OK},
    '{CMD_TRY,     8'd255, 1'b1, 8'd1, STAT_OK},
    '{CMD_ALLOC,   8'd0,   1'b1, 8'd0, STAT_OK},
    '{CMD_TRY,     8'd0,   1'b1, 8'd0, STAT_NONE_FREE},
    '{CMD_ALLOC,   8'd0,   1'b1, 8'd3, STAT_OK},
    '{CMD_RELEASE, 8'd2,   1'b1, 8'd0, STAT_OK},
    '{CMD_RELEASE, 8'd3,   1'b1, 8'd0, STAT_OK},
    '{CMD_RELEASE, 8'd200, 1'b1, 8'd0, STAT_BAD_RELEASE},
    '{CMD_ALLOC,   8'd0,   1'b0, 8'd0, STAT_OK},
    '{CMD_TRY,     8'd0,   1'b0, 8'd0, STAT_OK},
    '{CMD_RELEASE, 8'hAA,  1'b1, 8'd0, STAT_BAD_RELEASE},
    '{CMD_RELEASE, 8'd0,   1'b1, 8'd0, STAT_OK},
    '{CmdUnknown,  8'h55,  1'b1, 8'd0, STAT_NONE_FREE}
  };

  function automatic grant_t pool_apply(logic [1:0] cmd, logic [HandleW-1:0] rel);
    grant_t g;
    g.handle = '0;
    g.status = STAT_NONE_FREE;
    case (cmd)
      CMD_ALLOC, CMD_TRY: begin
        if (recycled_q.size() > 0) begin
          g.handle = recycled_q.pop_front();
          held[g.handle] = 1'b1;
          g.status = STAT_OK;
        end else if (cmd == CMD_TRY) begin
          g.status = STAT_NONE_FREE;
        end else if (next_fresh < PoolSize) begin
          g.handle = HandleW'(next_fresh);
          next_fresh++;
          held[g.handle] = 1'b1;
          g.status = STAT_OK;
        end else begin
          g.status = STAT_EXHAUSTED;
        end
      end
      CMD_RELEASE: begin
        if (rel < PoolSize && held[rel] && recycled_q.size() < PoolSize) begin
          held[rel] = 1'b0;
          recycled_q.insert(recycled_q.size(), rel);
          g.status = STAT_OK;
        end else begin
          g.status = STAT_BAD_RELEASE;
        end
      end
      default: ;
    endcase
    return g;
  endfunction

  // Find a handle that is currently out, scanning from a random start
  function automatic logic [HandleW-1:0] pick_held();
    int unsigned start;
    start = $urandom_range(0, PoolSize - 1);
    for (int unsigned k = 0; k < PoolSize; k++) begin
      if (held[(start + k) % PoolSize]) begin
        return HandleW'((start + k) % PoolSize);
      end
    end
    return HandleW'(start);
  endfunction

  // Called just after a rising edge; returns just after the edge that took the item, or after an idle gap
  task automatic offer_item(input logic [1:0] cmd, input logic [HandleW-1:0] rel,
                            input bit known, input grant_t typed);
    grant_t g;
    bit stalled;
    int unsigned gap;
    in_valid_i <= 1'b1;
    cmd_i <= cmd;
    release_handle_i <= rel;
    do begin
      @(negedge clk_i);
      stalled = in_stall_o;
      @(posedge clk_i);
    end while (stalled);
    g = pool_apply(cmd, rel);
    if (g.status == STAT_EXHAUSTED) begin
      exhaust_hits++;
    end
    grant_q.insert(grant_q.size(), known ? typed : g);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic offer_random(input int unsigned pct_alloc, input int unsigned pct_try,
                              input int unsigned pct_good_rel, input int unsigned pct_bad_rel);
    int unsigned r;
    grant_t none;
    none = '0;
    r = $urandom_range(0, 99);
    if (r < pct_alloc) begin
      offer_item(CMD_ALLOC, HandleW'($urandom_range(0, 255)), 1'b0, none);
    end else if (r < pct_alloc + pct_try) begin
      offer_item(CMD_TRY, HandleW'($urandom_range(0, 255)), 1'b0, none);
    end else if (r < pct_alloc + pct_try + pct_good_rel) begin
      offer_item(CMD_RELEASE, pick_held(), 1'b0, none);
    end else if (r < pct_alloc + pct_try + pct_good_rel + pct_bad_rel) begin
      offer_item(CMD_RELEASE, HandleW'($urandom_range(0, 255)), 1'b0, none);
    end else begin
      offer_item(CmdUnknown, HandleW'($urandom_range(0, 255)), 1'b0, none);
    end
  endtask

  initial begin
    clk_i = 1'b0;
  end

  always #10 clk_i = ~clk_i;

  initial begin
    int unsigned spin;
    grant_t typed;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    cmd_i = CMD_ALLOC;
    release_handle_i = '0;
    fail_count = 0;
    exhaust_hits = 0;
    burst_left = 0;
    next_fresh = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (pool_rows[i]) begin
      typed.handle = pool_rows[i].handle;
      typed.status = pool_rows[i].status;
      offer_item(pool_rows[i].cmd, pool_rows[i].rel, pool_rows[i].known, typed);
    end

    // Fill the pool until allocation runs dry several times
    while (exhaust_hits < ExhaustTarget) begin
      offer_random(85, 3, 7, 3);
    end
    // Churn: releases refill the queue, allocs and tries drain it again
    repeat (MixItems) begin
      offer_random(20, 20, 45, 10);
    end
    in_valid_i <= 1'b0;

    spin = 0;
    while (grant_q.size() != 0 && spin < 20000) begin
      @(posedge clk_i);
      spin++;
    end
    repeat (8) @(posedge clk_i);
    if (grant_q.size() != 0) begin
      $error("%0d expected results never arrived", grant_q.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("** handle_pool_allocator: PASSED **");
    end else begin
      $display("** handle_pool_allocator: FAILED **");
    end
    $finish;
  end

  // Receiver: stall pattern changes every segment; a long hold-off fills the block
  initial begin
    int unsigned cyc;
    int unsigned seg_left;
    int unsigned mode;
    int unsigned hold_left;
    bit stall;
    out_stall_i = 1'b0;
    cyc = 0;
    seg_left = 0;
    mode = 0;
    hold_left = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      cyc++;
      if (cyc % 1500 == 300) begin
        hold_left = 60;
      end
      if (seg_left == 0) begin
        seg_left = $urandom_range(16, 48);
        mode = $urandom_range(0, 3);
      end else begin
        seg_left--;
      end
      if (hold_left > 0) begin
        stall = 1'b1;
        hold_left--;
      end else begin
        case (mode)
          0: stall = 1'b0;
          1: stall = ($urandom_range(0, 3) == 0);
          2: stall = ($urandom_range(0, 3) != 0);
          default: stall = cyc[0];
        endcase
      end
      out_stall_i <= stall;
    end
  end

  // Compare each taken result with the oldest expectation
  always @(negedge clk_i) begin : check_result
    grant_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (grant_q.size() == 0) begin
        $error("unexpected result: granted_handle %0d status %0d", granted_handle_o, status_o);
        fail_count++;
      end else begin
        want = grant_q.pop_front();
        if (granted_handle_o !== want.handle) begin
          $error("granted_handle: expected %0d, got %0d", want.handle, granted_handle_o);
          fail_count++;
        end
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #3000000;
    $display("** handle_pool_allocator: FAILED **");
    $finish;
  end

endmodule
